/* sv/sad_stereo_disparity_top_assert.svh */
// Assertion helpers shared by the disparity block
`ifndef SAD_STEREO_DISPARITY_TOP_ASSERT_SVH
`define SAD_STEREO_DISPARITY_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SSD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/ssd_pkg.sv */
package ssd_pkg;

  localparam int PIX_W      = 8;
  localparam int DISP_W     = 6;
  localparam int W_REG_W    = 12;
  localparam int H_REG_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [W_REG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [H_REG_W-1:0] HEIGHT_RESET = 13'd480;

  // input word: one left/right pixel pair
  typedef struct packed {
    logic [PIX_W-1:0] left_pixel;
    logic [PIX_W-1:0] right_pixel;
    logic             flush;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [DISP_W-1:0] disparity;
    logic              last_of_frame;
  } out_word_t;

endpackage

/* sv/ssd_lbuf.sv */
module ssd_lbuf import ssd_pkg::*; #(
  parameter int WH          = 7,
  parameter int LINE_LENGTH = 2048,
  parameter int XW          = 11
) (
  input  logic               clk,
  input  logic               en,
  input  logic               rd_ev,
  input  logic [XW-1:0]      rd_x,
  input  logic [PIX_W-1:0]   lpix,
  input  logic [PIX_W-1:0]   rpix,
  input  logic               wr_vld,
  input  logic [XW-1:0]      wr_x,
  input  logic [WH-1:0]      row_mask,
  output logic [WH*PIX_W-1:0] lcol,
  output logic [WH*PIX_W-1:0] rcol
);

  localparam int HW = (WH - 1) * PIX_W;   // one side of a memory row
  localparam int MW = 2 * HW;

  logic [MW-1:0]       mem [LINE_LENGTH];
  logic [MW-1:0]       rd_r;
  logic [MW-1:0]       bypw_r;
  logic                byp_r;
  logic [PIX_W-1:0]    l1_r;
  logic [PIX_W-1:0]    r1_r;
  logic [MW-1:0]       word_s1;
  logic [MW-1:0]       wword;
  logic [WH*PIX_W-1:0] lfull;
  logic [WH*PIX_W-1:0] rfull;
  logic [WH*PIX_W-1:0] lmask;
  logic [WH*PIX_W-1:0] rmask;
  logic [WH*PIX_W-1:0] lcol_r;
  logic [WH*PIX_W-1:0] rcol_r;

  // older rows from memory, newest pixel on top
  always_comb begin
    word_s1 = byp_r ? bypw_r : rd_r;
    lfull   = {l1_r, word_s1[HW-1:0]};
    rfull   = {r1_r, word_s1[MW-1:HW]};
    wword   = {rfull[WH*PIX_W-1:PIX_W], lfull[WH*PIX_W-1:PIX_W]};
    for (int i = 0; i < WH; i++) begin
      lmask[i*PIX_W +: PIX_W] = row_mask[i] ? lfull[i*PIX_W +: PIX_W] : '0;
      rmask[i*PIX_W +: PIX_W] = row_mask[i] ? rfull[i*PIX_W +: PIX_W] : '0;
    end
  end

  // line memory: read at accept, write back the shifted column from the registered write tag
  always_ff @(posedge clk) begin
    if (en && rd_ev) begin
      rd_r <= mem[rd_x];
    end
    if (en && wr_vld) begin
      mem[wr_x] <= wword;
    end
  end

  // same-address bypass (one-pixel rows) and column registers
  always_ff @(posedge clk) begin
    if (en) begin
      byp_r  <= wr_vld && (wr_x == rd_x);
      bypw_r <= wword;
      l1_r   <= lpix;
      r1_r   <= rpix;
      lcol_r <= lmask;
      rcol_r <= rmask;
    end
  end

  assign lcol = lcol_r;
  assign rcol = rcol_r;

endmodule

/* sv/ssd_cell.sv */
module ssd_cell import ssd_pkg::*; #(
  parameter int DIS  = 0,
  parameter int WH   = 7,
  parameter int WW   = 7,
  parameter int XW   = 11,
  parameter int CSW  = 11,
  parameter int SADW = 14
) (
  input  logic                clk,
  input  logic                en,
  input  logic                col_vld,
  input  logic [XW-1:0]       col_x,
  input  logic [WH*PIX_W-1:0] lcol,
  input  logic [WH*PIX_W-1:0] rcol_in,
  output logic [WH*PIX_W-1:0] rcol_out,
  input  logic                hist_vld,
  input  logic [WW-1:0]       col_mask,
  output logic [SADW-1:0]     win_sad
);

  logic [WH*PIX_W-1:0] rcol_r;
  logic [CSW-1:0]      colsum_nxt;
  logic [CSW-1:0]      colsum_r;
  logic [CSW-1:0]      hist_r [WW-1];
  logic [SADW-1:0]     win_nxt;
  logic [SADW-1:0]     win_r;

  // column SAD; right pixels left of column 0 read as zero
  always_comb begin
    logic [PIX_W-1:0] lv;
    logic [PIX_W-1:0] rv;
    logic [PIX_W-1:0] ad;
    colsum_nxt = '0;
    for (int i = 0; i < WH; i++) begin
      lv = lcol[i*PIX_W +: PIX_W];
      rv = (int'(col_x) < DIS) ? '0 : rcol_in[i*PIX_W +: PIX_W];
      ad = (lv > rv) ? lv - rv : rv - lv;
      colsum_nxt = colsum_nxt + CSW'(ad);
    end
  end

  // window: newest column plus history, columns outside the row dropped
  always_comb begin
    win_nxt = col_mask[0] ? SADW'(colsum_r) : '0;
    for (int j = 1; j < WW; j++) begin
      if (col_mask[j]) begin
        win_nxt = win_nxt + SADW'(hist_r[j-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      colsum_r <= colsum_nxt;
      win_r    <= win_nxt;
      // right column moves one cell per column word
      if (col_vld) begin
        rcol_r <= rcol_in;
      end
      if (hist_vld) begin
        hist_r[0] <= colsum_r;
        for (int j = 1; j < WW - 1; j++) begin
          hist_r[j] <= hist_r[j-1];
        end
      end
    end
  end

  assign rcol_out = rcol_r;
  assign win_sad  = win_r;

endmodule

/* sv/ssd_min_tree.sv */
module ssd_min_tree import ssd_pkg::*; #(
  parameter int N    = 64,
  parameter int SADW = 14,
  parameter int IW   = 6
) (
  input  logic            clk,
  input  logic            en,
  input  logic [N*SADW-1:0] sads,
  output logic [IW-1:0]   best_idx
);

  localparam int LV = IW;
  localparam int P  = 1 << LV;

  logic [SADW-1:0] lvl_v  [LV+1][P];
  logic [IW-1:0]   lvl_ix [LV+1][P];
  logic [SADW-1:0] vr     [LV][P/2];
  logic [IW-1:0]   ixr    [LV][P/2];

  // leaves padded with the largest sum; upper levels from registers
  always_comb begin
    for (int k = 0; k < P; k++) begin
      lvl_v[0][k]  = (k < N) ? sads[k*SADW +: SADW] : '1;
      lvl_ix[0][k] = IW'(k);
      for (int l = 1; l <= LV; l++) begin
        lvl_v[l][k]  = (k < P/2) ? vr[l-1][k % (P/2)]  : '1;
        lvl_ix[l][k] = (k < P/2) ? ixr[l-1][k % (P/2)] : '0;
      end
    end
  end

  // one compare level per stage; ties keep the lower index
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LV; l++) begin
        for (int k = 0; k < P/2; k++) begin
          if (lvl_v[l][2*k] <= lvl_v[l][2*k+1]) begin
            vr[l][k]  <= lvl_v[l][2*k];
            ixr[l][k] <= lvl_ix[l][2*k];
          end else begin
            vr[l][k]  <= lvl_v[l][2*k+1];
            ixr[l][k] <= lvl_ix[l][2*k+1];
          end
        end
      end
    end
  end

  assign best_idx = lvl_ix[LV][0];

endmodule

/* sv/sad_stereo_disparity_top.sv */
// SAD block-matching stereo, winner take all, one pixel pair per clock when not stalled.
// Input channel (in_valid/in_stall/in_word): left and right grey pixels in
// raster order; after the frame, words with flush=1 drain the last results.
// Flush words inside the frame are taken and dropped.
// Output channel (out_valid/out_stall/out_word): one disparity per pixel,
// last_of_frame marks the final one; the frame then restarts.
// Config port: cfg_we with cfg_index 0 (image width) or 1 (image height);
// a write restarts the frame. Write only while the block is idle.
// Throughput: one word per clock while not stalled. The window result for a pixel is due
// 3*width+3 words after it (7x7 window); once due, it passes the line memory read,
// the column/window stages of the disparity cell chain and the min tree, one compare
// level per stage, then enters the output queue, where it raises out_valid.
// A two-entry output queue lets input run on while a result waits; input
// stalls only when that queue is full and then the whole pipe holds.
// Reset (synchronous, rst_n low) restores 640x480 and an empty pipe; the
// line memory is not cleared, rows outside the frame are masked instead.
`include "sad_stereo_disparity_top_assert.svh"

module sad_stereo_disparity_top import ssd_pkg::*; #(
  parameter int MAX_DISPARITY = 64,
  parameter int WINDOW_HEIGHT = 7,
  parameter int WINDOW_WIDTH  = 7,
  parameter int LINE_LENGTH   = 2048
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WH       = WINDOW_HEIGHT;
  localparam int WW       = WINDOW_WIDTH;
  localparam int XW       = $clog2(LINE_LENGTH);
  localparam int EW       = $clog2(LINE_LENGTH + 1);
  localparam int LAG_ROWS = WH - 1 - WH / 2;
  localparam int LAG_COLS = WW - 1 - WW / 2;
  localparam int LAGW     = $clog2(LAG_ROWS * LINE_LENGTH + LAG_COLS + 1);
  localparam int CSW      = $clog2(WH * 255 + 1);
  localparam int SADW     = $clog2(WH * WW * 255 + 1);
  localparam int IW       = $clog2(MAX_DISPARITY);
  localparam int LCW      = WH * PIX_W;
  localparam logic [1:0] FIFO_FULL = 2'd2;

  // config and frame position
  logic [W_REG_W-1:0] width_r;
  logic [H_REG_W-1:0] height_r;
  logic [XW-1:0]      x_cnt_r;
  logic [H_REG_W-1:0] y_cnt_r;
  logic               drain_r;
  logic [LAGW-1:0]    kc_r;
  logic [XW-1:0]      oc_r;
  logic [H_REG_W-1:0] or_r;

  logic [EW-1:0]      eff_w;
  logic [H_REG_W-1:0] eff_h;
  logic [LAGW-1:0]    lag;
  logic               en;
  logic               acc;
  logic               ev;
  logic               emit0;
  logic               last0;
  logic               x_last;
  logic               y_last;
  logic               oc_last;
  logic               or_last;
  logic               cfg_hit;
  logic [WH-1:0]      rm0;
  logic [WW-1:0]      cm0;

  // pipeline tags
  logic               v1_r, em1_r, la1_r;
  logic [XW-1:0]      x1_r;
  logic [WH-1:0]      rm1_r;
  logic [WW-1:0]      cm1_r;
  logic               v2_r, em2_r, la2_r;
  logic [XW-1:0]      x2_r;
  logic [WW-1:0]      cm2_r;
  logic               v3_r, em3_r, la3_r;
  logic [WW-1:0]      cm3_r;
  logic               em4_r, la4_r;
  logic [IW-1:0]      em_p_r;
  logic [IW-1:0]      la_p_r;

  logic [LCW-1:0]     lcol_s2;
  logic [LCW-1:0]     rcol_s2;
  logic [LCW-1:0]     rchain [MAX_DISPARITY+1];
  logic [MAX_DISPARITY*SADW-1:0] sads;
  logic [IW-1:0]      best_idx;

  // output queue
  out_word_t          ent_r [2];
  logic               wp_r, rp_r;
  logic [1:0]         cnt_r;
  logic               push;
  logic               pop;

  // effective frame size and result lag
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (int'(width_r) > LINE_LENGTH) begin
      eff_w = EW'(LINE_LENGTH);
    end else begin
      eff_w = EW'(width_r);
    end
    eff_h = (height_r == '0) ? H_REG_W'(1) : height_r;
    lag   = LAGW'(LAG_ROWS * int'(eff_w) + LAG_COLS);
  end

  // handshake and per-word tags
  always_comb begin
    int ty;
    int cc;
    en      = (cnt_r != FIFO_FULL);
    acc     = in_valid && !in_stall;
    ev      = acc && (drain_r || !in_word.flush);
    x_last  = (EW'(x_cnt_r) == eff_w - EW'(1));
    y_last  = (y_cnt_r == eff_h - H_REG_W'(1));
    oc_last = (EW'(oc_r) == eff_w - EW'(1));
    or_last = (or_r == eff_h - H_REG_W'(1));
    emit0   = (kc_r == lag);
    last0   = emit0 && oc_last && or_last;
    cfg_hit = cfg_we && ((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));
    for (int i = 0; i < WH; i++) begin
      ty     = int'(y_cnt_r) + i;
      rm0[i] = (ty >= WH - 1) && (ty < int'(eff_h) + WH - 1);
    end
    for (int j = 0; j < WW; j++) begin
      cc     = int'(oc_r) + LAG_COLS - j;
      cm0[j] = (cc >= 0) && (cc < int'(eff_w));
    end
  end

  assign in_stall = !en;

  // config registers and frame counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      x_cnt_r  <= '0;
      y_cnt_r  <= '0;
      drain_r  <= 1'b0;
      kc_r     <= '0;
      oc_r     <= '0;
      or_r     <= '0;
    end else if (cfg_hit) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[W_REG_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[H_REG_W-1:0];
        default: ;
      endcase
      x_cnt_r <= '0;
      y_cnt_r <= '0;
      drain_r <= 1'b0;
      kc_r    <= '0;
      oc_r    <= '0;
      or_r    <= '0;
    end else if (en && ev) begin
      if (last0) begin
        x_cnt_r <= '0;
        y_cnt_r <= '0;
        drain_r <= 1'b0;
        kc_r    <= '0;
        oc_r    <= '0;
        or_r    <= '0;
      end else begin
        if (x_last) begin
          x_cnt_r <= '0;
          y_cnt_r <= y_cnt_r + 1'b1;
        end else begin
          x_cnt_r <= x_cnt_r + 1'b1;
        end
        if (!drain_r && x_last && y_last) begin
          drain_r <= 1'b1;
        end
        if (!emit0) begin
          kc_r <= kc_r + 1'b1;
        end else if (oc_last) begin
          oc_r <= '0;
          or_r <= or_r + 1'b1;
        end else begin
          oc_r <= oc_r + 1'b1;
        end
      end
    end
  end

  // tag valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      em1_r  <= 1'b0;
      la1_r  <= 1'b0;
      v2_r   <= 1'b0;
      em2_r  <= 1'b0;
      la2_r  <= 1'b0;
      v3_r   <= 1'b0;
      em3_r  <= 1'b0;
      la3_r  <= 1'b0;
      em4_r  <= 1'b0;
      la4_r  <= 1'b0;
      em_p_r <= '0;
      la_p_r <= '0;
    end else if (en) begin
      v1_r   <= ev;
      em1_r  <= ev && emit0;
      la1_r  <= ev && last0;
      v2_r   <= v1_r;
      em2_r  <= em1_r;
      la2_r  <= la1_r;
      v3_r   <= v2_r;
      em3_r  <= em2_r;
      la3_r  <= la2_r;
      em4_r  <= em3_r;
      la4_r  <= la3_r;
      em_p_r <= {em_p_r[IW-2:0], em4_r};
      la_p_r <= {la_p_r[IW-2:0], la4_r};
    end
  end

  // tag payload
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x_cnt_r;
      rm1_r <= rm0;
      cm1_r <= cm0;
      x2_r  <= x1_r;
      cm2_r <= cm1_r;
      cm3_r <= cm2_r;
    end
  end

  ssd_lbuf #(
    .WH          (WH),
    .LINE_LENGTH (LINE_LENGTH),
    .XW          (XW)
  ) u_lbuf (
    .clk      (clk),
    .en       (en),
    .rd_ev    (ev),
    .rd_x     (x_cnt_r),
    .lpix     (in_word.left_pixel),
    .rpix     (in_word.right_pixel),
    .wr_vld   (v1_r),
    .wr_x     (x1_r),
    .row_mask (rm1_r),
    .lcol     (lcol_s2),
    .rcol     (rcol_s2)
  );

  // one cell per disparity, right column marching down the chain
  assign rchain[0] = rcol_s2;

  for (genvar d = 0; d < MAX_DISPARITY; d++) begin : g_cell
    ssd_cell #(
      .DIS  (d),
      .WH   (WH),
      .WW   (WW),
      .XW   (XW),
      .CSW  (CSW),
      .SADW (SADW)
    ) u_cell (
      .clk      (clk),
      .en       (en),
      .col_vld  (v2_r),
      .col_x    (x2_r),
      .lcol     (lcol_s2),
      .rcol_in  (rchain[d]),
      .rcol_out (rchain[d+1]),
      .hist_vld (v3_r),
      .col_mask (cm3_r),
      .win_sad  (sads[d*SADW +: SADW])
    );
  end

  ssd_min_tree #(
    .N    (MAX_DISPARITY),
    .SADW (SADW),
    .IW   (IW)
  ) u_min (
    .clk      (clk),
    .en       (en),
    .sads     (sads),
    .best_idx (best_idx)
  );

  // two-entry output queue
  assign push = en && em_p_r[IW-1];
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r].disparity     <= DISP_W'(best_idx);
      ent_r[wp_r].last_of_frame <= la_p_r[IW-1];
    end
  end

  assign out_valid = (cnt_r != '0);
  assign out_word  = ent_r[rp_r];

  `SSD_ASSERT_IMP(a_stall_full, in_stall, cnt_r == FIFO_FULL, "input stalled with room in queue")
  `SSD_ASSERT_IMP(a_no_overflow, push, cnt_r != FIFO_FULL, "result pushed into a full queue")
  `SSD_ASSERT_NXT(a_frame_restart, en && ev && last0 && !cfg_we,
    (x_cnt_r == '0) && (y_cnt_r == '0) && !drain_r && (kc_r == '0), "frame did not restart")
  `SSD_ASSERT_IMP(a_emit_tagged, em1_r || la1_r, v1_r && em1_r, "result tag on an empty slot")

endmodule

/* tb/tb_sad_stereo_disparity_top.sv */
`default_nettype none

// Scoreboard: tracks the frame like the block does, predicts each disparity
// word and checks results in order.
class disparity_scoreboard;
  localparam int WIN_H = 7;
  localparam int WIN_W = 7;
  localparam int MAX_DISP = 64;
  localparam int MAX_LINE = 2048;
  localparam int RING = WIN_H * MAX_LINE + WIN_W + MAX_DISP;

  int unsigned width_reg = 640;
  int unsigned height_reg = 480;
  int unsigned frame_items = 0;
  byte unsigned left_mem [RING];
  byte unsigned right_mem [RING];
  ssd_pkg::out_word_t disparity_due [$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned frames_done = 0;

  function int unsigned used_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_LINE) return MAX_LINE;
    return width_reg;
  endfunction

  function int unsigned used_height();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  // register write: takes effect at once and restarts the frame
  function void write_reg(logic [ssd_pkg::CFG_IDX_W-1:0] idx,
                          logic [ssd_pkg::CFG_DATA_W-1:0] val);
    if (idx == ssd_pkg::REG_IMAGE_WIDTH) begin
      width_reg = val & 13'hFFF;
      frame_items = 0;
    end else if (idx == ssd_pkg::REG_IMAGE_HEIGHT) begin
      height_reg = val;
      frame_items = 0;
    end
  endfunction

  // SAD over the window around (r,c) at disparity d; outside taps add zero
  function int unsigned window_sad(int r, int c, int d, int w, int h);
    int unsigned sum;
    int y, x, xr, lv, rv;
    sum = 0;
    for (int dy = 0; dy < WIN_H; dy++) begin
      y = r - WIN_H / 2 + dy;
      if (y < 0 || y >= h) continue;
      for (int dx = 0; dx < WIN_W; dx++) begin
        x = c - WIN_W / 2 + dx;
        xr = x - d;
        if (x < 0 || x >= w) continue;
        lv = left_mem[(y * w + x) % RING];
        rv = (xr >= 0) ? right_mem[(y * w + xr) % RING] : 0;
        sum += (lv > rv) ? lv - rv : rv - lv;
      end
    end
    return sum;
  endfunction

  // accepted input word: store pixel, maybe queue the disparity now due
  function void note_input(ssd_pkg::in_word_t wd);
    int unsigned w, h, total, lag, q, best, s, best_d;
    int r, c;
    ssd_pkg::out_word_t res;
    w = used_width();
    h = used_height();
    total = w * h;
    lag = (WIN_H - 1 - WIN_H / 2) * w + (WIN_W - 1 - WIN_W / 2);
    if (!wd.flush && frame_items < total) begin
      left_mem[frame_items % RING] = wd.left_pixel;
      right_mem[frame_items % RING] = wd.right_pixel;
      frame_items++;
    end else if (frame_items >= total) begin
      frame_items++;
    end else begin
      return;
    end
    if (frame_items <= lag) return;
    q = frame_items - 1 - lag;
    r = q / w;
    c = q % w;
    best = 32'hFFFF_FFFF;
    best_d = 0;
    for (int d = 0; d < MAX_DISP; d++) begin
      s = window_sad(r, c, d, w, h);
      if (s < best) begin
        best = s;
        best_d = d;
      end
    end
    res.disparity = best_d[5:0];
    res.last_of_frame = (q + 1 == total);
    disparity_due.push_back(res);
    if (q + 1 >= total) begin
      frame_items = 0;
      frames_done++;
    end
  endfunction

  // accepted result word against the oldest prediction
  function void check_result(ssd_pkg::out_word_t got);
    ssd_pkg::out_word_t exp_w;
    results_seen++;
    if (disparity_due.size() == 0) begin
      $display("%0t: unexpected result word disparity=%0d last=%0d",
               $realtime, got.disparity, got.last_of_frame);
      mismatches++;
      return;
    end
    exp_w = disparity_due.pop_front();
    if (got.disparity !== exp_w.disparity) begin
      $display("%0t: disparity expected %0d actual %0d", $realtime,
               exp_w.disparity, got.disparity);
      mismatches++;
    end
    if (got.last_of_frame !== exp_w.last_of_frame) begin
      $display("%0t: last_of_frame expected %0d actual %0d", $realtime,
               exp_w.last_of_frame, got.last_of_frame);
      mismatches++;
    end
  endfunction
endclass

module tb_sad_stereo_disparity_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd2;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  disparity_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned random_items = 0;
  int unsigned config_writes = 0;
  bit held_off = 1'b0;

  sad_stereo_disparity_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // receiver: random stall pattern from three modes (none, light, heavy), plus one long hold-off
  // started while the sender is offering words
  initial begin
    int unsigned mode;
    int unsigned hold;
    int unsigned cyc;
    mode = 0;
    hold = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      if (!held_off && in_valid && sb.results_seen >= 40) begin
        held_off = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (cyc % 32 == 0) mode = $urandom_range(0, 2);
      cyc++;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 9) < 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  // one input word, held until accepted, then sometimes a gap at the end of a burst
  task automatic send_word(input in_word_t wd);
    int unsigned gap;
    in_valid <= 1'b1;
    in_word <= wd;
    do @(posedge clk); while (in_stall);
    sb.note_input(wd);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic send_pixels(input logic [7:0] lp, input logic [7:0] rp,
                             input logic fl);
    in_word_t wd;
    wd.left_pixel = lp;
    wd.right_pixel = rp;
    wd.flush = fl;
    send_word(wd);
  endtask

  // register write while idle: wait for pending results, then settle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    wait (sb.disparity_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    config_writes++;
  endtask

  // a whole frame: random pixels, stray flushes inside, then drain words
  task automatic run_frame();
    int unsigned w, h, lag;
    w = sb.used_width();
    h = sb.used_height();
    lag = 3 * w + 3;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 19) == 0) send_pixels(8'($urandom), 8'($urandom), 1'b1);
      send_pixels(8'($urandom), 8'($urandom), 1'b0);
      random_items++;
    end
    for (int unsigned i = 0; i < lag; i++) begin
      send_pixels(8'($urandom), 8'($urandom), $urandom_range(0, 3) != 0);
      random_items++;
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] wv, hv;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4x3 frame with pixel extremes, in-frame flush, overrun pixel
    write_reg(REG_IMAGE_WIDTH, 13'd4);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    send_pixels(8'd0, 8'd255, 1'b0);
    send_pixels(8'd255, 8'd0, 1'b0);
    send_pixels(8'd255, 8'd255, 1'b1);
    send_pixels(8'd255, 8'd255, 1'b0);
    send_pixels(8'd0, 8'd0, 1'b0);
    for (int i = 0; i < 8; i++) send_pixels(8'hAA ^ 8'(i * 37), 8'h55 + 8'(i), 1'b0);
    send_pixels(8'd255, 8'd0, 1'b0);
    for (int i = 0; i < 14; i++) send_pixels(8'd0, 8'd0, 1'b1);

    // zero sizes, unused register index
    write_reg(REG_IMAGE_WIDTH, 13'd0);
    write_reg(REG_IMAGE_HEIGHT, 13'd0);
    write_reg(REG_UNUSED, 13'h1ABC);
    run_frame();
    run_frame();

    // random small frames
    random_items = 0;
    while (random_items < 340) begin
      wv = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 9));
      hv = ($urandom_range(0, 15) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
      write_reg(REG_IMAGE_WIDTH, wv);
      if ($urandom_range(0, 3) != 0) write_reg(REG_IMAGE_HEIGHT, hv);
      repeat ($urandom_range(1, 3)) run_frame();
    end

    // one column, much taller than the window
    write_reg(REG_IMAGE_WIDTH, 13'd1);
    write_reg(REG_IMAGE_HEIGHT, 13'd64);
    run_frame();

    in_valid <= 1'b0;
    wait (sb.disparity_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d frames, %0d result words, %0d register writes,",
             sb.frames_done, sb.results_seen, config_writes);
    $display("sizes from 1x1 to 9x6 plus a 1x64 column, with stray flushes and stalls");
    if (sb.mismatches == 0 && sb.disparity_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10ms;
    $display("timeout waiting on the block");
    $display("end of test: mismatches");
    $finish;
  end
endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/ssd_pkg.sv
sv/ssd_lbuf.sv
sv/ssd_cell.sv
sv/ssd_min_tree.sv
sv/sad_stereo_disparity_top.sv
tb/tb_sad_stereo_disparity_top.sv
